### hdl/pfde_pkg.sv
// Shared types and constants for the page frame store draw engine.
// Used by the sequencer and the top level; no dependencies.
package pfde_pkg;

  // Rows packed into one stored byte
  localparam int PAGE_ROWS = 8;

  // Command codes carried on the input channel's tuser
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_RECT  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // One command as taken from the input channel
  typedef struct packed {
    op_t                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               color;
    logic [7:0]         width;
    logic [7:0]         height;
    logic [9:0]         byte_index;
  } cmd_t;

  // One finished command handed to the output register
  typedef struct packed {
    logic [7:0] read_data;
    logic       done_res;
  } res_t;

endpackage

### hdl/pfde_ram.sv
// Single-address frame store memory with registered read data.
// No dependencies; sized by the sequencer.
module pfde_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write on request, read the same address every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/pfde_seq.sv
// Command sequencer: clipping, address walk and read-modify-write of the store.
// Depends on pfde_pkg and pfde_ram.
module pfde_seq
  import pfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_accept,
  input  cmd_t cmd,
  output logic cmd_ready,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int IDX_W       = (ADDR_W > 10) ? ADDR_W : 10;
  localparam int IDX_CW      = IDX_W + 1;

  localparam logic signed [17:0] W_S       = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S       = 18'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0]  W_A       = ADDR_W'(SCREEN_WIDTH);
  localparam logic [IDX_CW-1:0]  STORE_C   = IDX_CW'(STORE_BYTES);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CLR  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_WR   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic               report_r, report_nxt;
  op_t                op_r, op_nxt;
  logic               color_r, color_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   c_lo_r, c_lo_nxt;
  logic [COL_W-1:0]   c_last_r, c_last_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [PAGE_W-1:0]  p_lo_r, p_lo_nxt;
  logic [PAGE_W-1:0]  p_last_r, p_last_nxt;
  logic [2:0]         rlo_r, rlo_nxt;
  logic [2:0]         rhi_r, rhi_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic [7:0]         data_r, data_nxt;

  // Clip arithmetic on the incoming command
  logic signed [17:0] xe, ye, cend, rend, cend_m1, rend_m1;
  logic signed [17:0] c_lo_s, c_hi_s, r_lo_s, r_hi_s;
  logic [17:0]        r_lo_sh, r_hi_sh, y_sh;
  logic               pix_on, rect_on;
  logic [PAGE_W-1:0]  pix_page, rect_p_lo, rect_p_hi;
  logic [ADDR_W-1:0]  pix_base, rect_base;
  logic [IDX_W-1:0]   bidx_ext;
  logic               bidx_ok;

  // Store access and rectangle byte mask
  logic               ram_we;
  logic [7:0]         ram_wdata, ram_rdata;
  logic [2:0]         m_lo, m_hi;
  logic [7:0]         rect_mask;
  logic [ADDR_W-1:0]  next_base;

  assign xe      = {{2{cmd.x[15]}}, cmd.x};
  assign ye      = {{2{cmd.y[15]}}, cmd.y};
  assign cend    = xe + $signed({10'd0, cmd.width});
  assign rend    = ye + $signed({10'd0, cmd.height});
  assign cend_m1 = cend - 18'sd1;
  assign rend_m1 = rend - 18'sd1;
  assign c_lo_s  = xe[17] ? 18'sd0 : xe;
  assign r_lo_s  = ye[17] ? 18'sd0 : ye;
  assign c_hi_s  = (cend > W_S) ? (W_S - 18'sd1) : cend_m1;
  assign r_hi_s  = (rend > H_S) ? (H_S - 18'sd1) : rend_m1;

  assign pix_on  = !xe[17] && (xe < W_S) && !ye[17] && (ye < H_S);
  assign rect_on = (xe < W_S) && (cend > 18'sd0) && (cmd.width != 8'd0) &&
                   (ye < H_S) && (rend > 18'sd0) && (cmd.height != 8'd0);

  assign y_sh      = ye >> 3;
  assign r_lo_sh   = r_lo_s >> 3;
  assign r_hi_sh   = r_hi_s >> 3;
  assign pix_page  = y_sh[PAGE_W-1:0];
  assign rect_p_lo = r_lo_sh[PAGE_W-1:0];
  assign rect_p_hi = r_hi_sh[PAGE_W-1:0];
  assign pix_base  = ADDR_W'(ADDR_W'(pix_page) * W_A);
  assign rect_base = ADDR_W'(ADDR_W'(rect_p_lo) * W_A);

  assign bidx_ext = IDX_W'(cmd.byte_index);
  assign bidx_ok  = IDX_CW'(bidx_ext) < STORE_C;

  // Rows of the current page covered by the rectangle
  assign m_lo      = (page_r == p_lo_r) ? rlo_r : 3'd0;
  assign m_hi      = (page_r == p_last_r) ? rhi_r : 3'd7;
  assign rect_mask = (8'hFF << m_lo) & (8'hFF >> (3'd7 - m_hi));
  assign next_base = base_r + W_A;

  // Sequencer next state
  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    op_nxt     = op_r;
    color_nxt  = color_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    col_nxt    = col_r;
    c_lo_nxt   = c_lo_r;
    c_last_nxt = c_last_r;
    page_nxt   = page_r;
    p_lo_nxt   = p_lo_r;
    p_last_nxt = p_last_r;
    rlo_nxt    = rlo_r;
    rhi_nxt    = rhi_r;
    mask_nxt   = mask_r;
    data_nxt   = data_r;
    ram_we     = 1'b0;
    ram_wdata  = 8'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_accept) begin
          op_nxt    = cmd.op;
          color_nxt = cmd.color;
          data_nxt  = 8'd0;
          unique case (cmd.op)
            OP_CLEAR: begin
              addr_nxt   = '0;
              report_nxt = 1'b1;
              state_nxt  = ST_CLR;
            end
            OP_PIXEL: begin
              addr_nxt  = pix_base + ADDR_W'(c_lo_s[COL_W-1:0]);
              mask_nxt  = 8'd1 << ye[2:0];
              state_nxt = pix_on ? ST_RD : ST_DONE;
            end
            OP_RECT: begin
              c_lo_nxt   = c_lo_s[COL_W-1:0];
              c_last_nxt = c_hi_s[COL_W-1:0];
              col_nxt    = c_lo_s[COL_W-1:0];
              p_lo_nxt   = rect_p_lo;
              p_last_nxt = rect_p_hi;
              page_nxt   = rect_p_lo;
              rlo_nxt    = r_lo_s[2:0];
              rhi_nxt    = r_hi_s[2:0];
              base_nxt   = rect_base;
              addr_nxt   = rect_base + ADDR_W'(c_lo_s[COL_W-1:0]);
              state_nxt  = rect_on ? ST_RD : ST_DONE;
            end
            OP_READ: begin
              addr_nxt  = bidx_ext[ADDR_W-1:0];
              state_nxt = bidx_ok ? ST_RD : ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // Sweep the store with zeros, one byte per cycle
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = 8'd0;
        if (addr_r == LAST_ADDR) begin
          state_nxt  = report_r ? ST_DONE : ST_IDLE;
          report_nxt = 1'b0;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // Store read issued at addr_r; data lands next cycle
      ST_RD: begin
        state_nxt = ST_WR;
      end

      // Modify and write back, then advance the walk; a read captures the byte instead
      ST_WR: begin
        case (op_r)
          OP_PIXEL: begin
            ram_we    = 1'b1;
            ram_wdata = color_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
            state_nxt = ST_DONE;
          end
          OP_RECT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | rect_mask;
            if (col_r == c_last_r) begin
              if (page_r == p_last_r) begin
                state_nxt = ST_DONE;
              end else begin
                page_nxt  = page_r + 1'b1;
                col_nxt   = c_lo_r;
                base_nxt  = next_base;
                addr_nxt  = next_base + ADDR_W'(c_lo_r);
                state_nxt = ST_RD;
              end
            end else begin
              col_nxt   = col_r + 1'b1;
              addr_nxt  = addr_r + 1'b1;
              state_nxt = ST_RD;
            end
          end
          default: begin
            data_nxt  = ram_rdata;
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Hold the result until the output register takes it
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state: reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      report_r <= 1'b0;
      addr_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
      addr_r   <= addr_nxt;
    end
  end

  // Command and walk registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    color_r  <= color_nxt;
    base_r   <= base_nxt;
    col_r    <= col_nxt;
    c_lo_r   <= c_lo_nxt;
    c_last_r <= c_last_nxt;
    page_r   <= page_nxt;
    p_lo_r   <= p_lo_nxt;
    p_last_r <= p_last_nxt;
    rlo_r    <= rlo_nxt;
    rhi_r    <= rhi_nxt;
    mask_r   <= mask_nxt;
    data_r   <= data_nxt;
  end

  pfde_ram #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cmd_ready     = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_DONE);
  assign res.read_data = data_r;
  assign res.done_res  = 1'b1;

endmodule

### hdl/page_framebuffer_draw_engine_unit.sv
// Top level of the page frame store draw engine: stream ports and output register.
// Depends on pfde_pkg and pfde_seq.
//
//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | tuser: op; tdata: x y color w h idx
//  output  | out_tvalid/out_tready/out_tdata| tdata: read_data done_res
//
// Pixel and read commands pass through a store read and then a write-back or
// capture; an off-screen pixel or a read past the store touches no byte. A
// rectangle fill reads and writes back each stored byte it touches (columns
// times pages), bound by the single store port's read-modify-write; clear
// writes all SCREEN_WIDTH * pages bytes. After reset the store is swept to
// zero over SCREEN_WIDTH * pages bytes (1024 by default) with in_tready low.
// A finished result waits in the output register while the next command is
// taken; the engine stalls only if a second result is ready before the first
// has gone.
module page_framebuffer_draw_engine_unit
  import pfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x[15:0] y[31:16] color[32] width[40:33]
                                  // height[48:41] byte_index[58:49], zero above
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0] done_res[8], zero above
);

  cmd_t        cmd;
  res_t        res;
  logic        cmd_accept, seq_ready, res_valid, res_ready;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [15:0] out_tdata_r, out_tdata_nxt;

  // Unpack the command transfer
  assign cmd.op         = op_t'(in_tuser);
  assign cmd.x          = in_tdata[15:0];
  assign cmd.y          = in_tdata[31:16];
  assign cmd.color      = in_tdata[32];
  assign cmd.width      = in_tdata[40:33];
  assign cmd.height     = in_tdata[48:41];
  assign cmd.byte_index = in_tdata[58:49];

  assign in_tready  = seq_ready;
  assign cmd_accept = in_tvalid && seq_ready;

  pfde_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_accept (cmd_accept),
    .cmd        (cmd),
    .cmd_ready  (seq_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_ready) begin
      out_tvalid_nxt = res_valid;
      out_tdata_nxt  = {7'd0, res.done_res, res.read_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### test/testbench.sv
// Self-checking testbench for page_framebuffer_draw_engine_unit: drives commands on the input
// stream, predicts each result from a local copy of the frame store and compares on transfer.
// Depends on pfde_pkg and the RTL of the draw engine.
`timescale 1ns / 100ps

module testbench;
  import pfde_pkg::*;

  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 64;
  localparam int PAGE_COUNT  = (SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_W * PAGE_COUNT;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_CMDS = 1130;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // Predicted frame store and the end column and row of the last fill
  logic [7:0]  frame_bytes [STORE_BYTES];
  logic [15:0] last_fill_col;
  logic [15:0] last_fill_row;

  res_t pending_results [$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  bit   steady_flow = 1'b0;

  page_framebuffer_draw_engine_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Set or clear one pixel, ignore anything off screen
  function automatic void plot_pixel(int col, int row, bit lit);
    int idx;
    if (col < 0 || col >= SCREEN_W || row < 0 || row >= SCREEN_H) return;
    idx = col + (row / PAGE_ROWS) * SCREEN_W;
    if (idx >= STORE_BYTES) return;
    frame_bytes[idx][row % PAGE_ROWS] = lit;
  endfunction

  // Apply one command to the predicted store and return the result it yields
  function automatic res_t draw_command(cmd_t c);
    res_t r;
    int   c0, r0, c1, r1;
    r.read_data = '0;
    r.done_res  = 1'b1;
    case (c.op)
      OP_CLEAR: begin
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
      end
      OP_PIXEL: plot_pixel(int'(c.x), int'(c.y), c.color);
      OP_RECT: begin
        c0 = (c.x < 0) ? 0 : int'(c.x);
        r0 = (c.y < 0) ? 0 : int'(c.y);
        c1 = int'(c.x) + int'(c.width);
        r1 = int'(c.y) + int'(c.height);
        last_fill_col = 16'(c1);
        last_fill_row = 16'(r1);
        if (c1 > SCREEN_W) c1 = SCREEN_W;
        if (r1 > SCREEN_H) r1 = SCREEN_H;
        // Rectangles always light, color is ignored
        for (int col = c0; col < c1; col++)
          for (int row = r0; row < r1; row++)
            plot_pixel(col, row, 1'b1);
      end
      default: begin
        if (c.byte_index < STORE_BYTES) r.read_data = frame_bytes[c.byte_index];
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t make_cmd(op_t op, int x, int y, bit color, int w, int h, int idx);
    cmd_t c;
    c.op         = op;
    c.x          = 16'(x);
    c.y          = 16'(y);
    c.color      = color;
    c.width      = 8'(w);
    c.height     = 8'(h);
    c.byte_index = 10'(idx);
    return c;
  endfunction

  // Send one command; called and returns at a falling edge
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {5'd0, c.byte_index, c.height, c.width, c.color, c.y, c.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(draw_command(c));
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
  endtask

  task automatic test_pixels();
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, SCREEN_W - 1, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, SCREEN_W - 1, 0, 0, 0, 0, 0));
    // Off-screen pixels must leave the store alone
    send_cmd(make_cmd(OP_PIXEL, -1, 5, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, SCREEN_W, 5, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, 5, SCREEN_H, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, -32768, 32767, 1, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, SCREEN_W - 1));
  endtask

  task automatic test_rects();
    // Clipped at the top left, color field low
    send_cmd(make_cmd(OP_RECT, -5, -3, 0, 10, 10, 0));
    send_cmd(make_cmd(OP_RECT, 60, 20, 1, 0, 9, 0));
    send_cmd(make_cmd(OP_RECT, 60, 20, 1, 9, 0, 0));
    // Clipped at the bottom right with the largest size
    send_cmd(make_cmd(OP_RECT, SCREEN_W - 8, SCREEN_H - 4, 1, 255, 255, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
  endtask

  task automatic test_full_and_clear();
    send_cmd(make_cmd(OP_RECT, 0, 0, 1, 255, 255, 1023));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 500));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 500));
  endtask

  // Random command mix, mostly near the screen with small rectangles
  task automatic test_random(int count);
    cmd_t c;
    int   pick;
    for (int n = 0; n < count; n++) begin
      steady_flow = (n >= 400 && n < 600);
      pick = $urandom_range(0, 99);
      c.op = (pick < 2) ? OP_CLEAR : (pick < 40) ? OP_PIXEL : (pick < 60) ? OP_RECT : OP_READ;
      if ($urandom_range(0, 9) == 0) begin
        c.x = 16'($urandom);
        c.y = 16'($urandom);
      end else begin
        c.x = 16'(int'($urandom_range(0, SCREEN_W + 15)) - 8);
        c.y = 16'(int'($urandom_range(0, SCREEN_H + 15)) - 8);
      end
      c.color      = 1'($urandom);
      c.width      = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
      c.height     = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
      c.byte_index = 10'($urandom);
      send_cmd(c);
    end
    steady_flow = 1'b0;
  endtask

  // Result receiver back-pressure
  always @(negedge clk) begin
    out_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_data=%02h done_res=%0b",
                 $time, out_tdata[7:0], out_tdata[8]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[7:0] !== want.read_data) begin
          $display("%0t: read_data mismatch expected %02h actual %02h",
                   $time, want.read_data, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[8] !== want.done_res) begin
          $display("%0t: done_res mismatch expected %0b actual %0b",
                   $time, want.done_res, out_tdata[8]);
          error_count++;
        end
      end
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    last_fill_col = '0;
    last_fill_row = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_pixels();
    test_rects();
    test_full_and_clear();
    test_random(RANDOM_CMDS);

    drain_results();
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
